[hw/rtl/mlaes_pkg.sv]
// Shared types, constants and AES round functions of the multi-lane CBC encryptor.
`timescale 1ns / 1ps
package mlaes_pkg;

    localparam int NUM_CELLS  = 14;
    localparam int NUM_WORDS  = 60;
    localparam int LANE_W     = 6;

    typedef enum logic [1:0] {
        KL_AES128 = 2'd0,
        KL_AES192 = 2'd1,
        KL_AES256 = 2'd2,
        KL_ALIAS  = 2'd3
    } t_key_len;

    typedef enum logic [2:0] {
        CFG_KEY0   = 3'd0,
        CFG_KEY1   = 3'd1,
        CFG_KEY2   = 3'd2,
        CFG_KEY3   = 3'd3,
        CFG_KEYLEN = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        MODE_LOAD    = 1'b0,
        MODE_ENCRYPT = 1'b1
    } t_mode;

    typedef logic [31:0] t_word;

    // Control that travels with a block down the cell row.
    typedef struct packed {
        logic              valid;
        logic [LANE_W-1:0] lane;
        logic              last;
    } t_tag;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_word sub_word(input t_word w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Key words of the cipher key for a key length code.
    function automatic logic [3:0] key_words(input logic [1:0] kl);
        logic [3:0] nk;
        case (kl)
            KL_AES128: nk = 4'd4;
            KL_AES192: nk = 4'd6;
            default:   nk = 4'd8;
        endcase
        return nk;
    endfunction

    // SubBytes, ShiftRows and (unless last) MixColumns; byte 0 is bits 127..120.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last_round);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   x;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            b[i] = SBOX[s[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                t[4*c+k] = b[4*((c+k)%4)+k];
            end
        end
        if (!last_round) begin
            for (int c = 0; c < 4; c++) begin
                x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                b[4*c]   = t[4*c]   ^ x ^ xtime(t[4*c]   ^ t[4*c+1]);
                b[4*c+1] = t[4*c+1] ^ x ^ xtime(t[4*c+1] ^ t[4*c+2]);
                b[4*c+2] = t[4*c+2] ^ x ^ xtime(t[4*c+2] ^ t[4*c+3]);
                b[4*c+3] = t[4*c+3] ^ x ^ xtime(t[4*c+3] ^ t[4*c]);
            end
        end else begin
            b = t;
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = b[i];
        end
        return r;
    endfunction

endpackage

[hw/rtl/mlaes_if.sv]
// Request and result channel interfaces of the multi-lane CBC encryptor.
`timescale 1ns / 1ps
interface mlaes_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [5:0]  lane;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        last_block;
    modport source (output valid, mode, lane, data_high, data_low, last_block, input ready);
    modport sink   (input valid, mode, lane, data_high, data_low, last_block, output ready);
endinterface

interface mlaes_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  out_lane;
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        out_last;
    modport source (output valid, out_lane, cipher_high, cipher_low, out_last, input ready);
    modport sink   (input valid, out_lane, cipher_high, cipher_low, out_last, output ready);
endinterface

[hw/rtl/mlaes_key_expand.sv]
// Sequential AES key schedule: one word per cycle into the round key registers.
`timescale 1ns / 1ps
module mlaes_key_expand
    import mlaes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_key [4],
    input  logic [1:0]  i_key_len,
    output t_word       o_rk [NUM_WORDS],
    output logic        o_done
);

    localparam int CW = $clog2(NUM_WORDS + 1);

    logic [CW-1:0] r_cnt;
    logic [2:0]    r_j;
    logic [7:0]    r_rcon;
    t_word         r_win [8];
    t_word         r_rk  [NUM_WORDS];
    logic [3:0]    nk;
    logic [CW-1:0] total;
    t_word         key_in;
    t_word         tmp;
    t_word         far;
    t_word         n_word;

    assign nk    = key_words(i_key_len);
    assign total = CW'(4 * (32'(nk) + 7));

    always_comb begin
        key_in = r_cnt[0] ? i_key[r_cnt[2:1]][31:0] : i_key[r_cnt[2:1]][63:32];
        case (i_key_len)
            KL_AES128: far = r_win[3];
            KL_AES192: far = r_win[5];
            default:   far = r_win[7];
        endcase
        tmp = r_win[0];
        if (r_j == 3'd0) begin
            tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {r_rcon, 24'h0};
        end else if (nk == 4'd8 && r_j == 3'd4) begin
            tmp = sub_word(tmp);
        end
        if (r_cnt >= total) begin
            n_word = '0;
        end else if (r_cnt < CW'(nk)) begin
            n_word = key_in;
        end else begin
            n_word = far ^ tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_cnt  <= '0;
            r_j    <= '0;
            r_rcon <= 8'h01;
        end else if (!o_done) begin
            r_cnt <= r_cnt + 1'b1;
            r_j   <= (4'(r_j) == nk - 4'd1) ? 3'd0 : r_j + 3'd1;
            if (r_cnt >= CW'(nk) && r_j == 3'd0) begin
                r_rcon <= xtime(r_rcon);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_done) begin
            r_rk[r_cnt[CW-1:0]] <= n_word;
            r_win[0] <= n_word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    assign o_done = (r_cnt == CW'(NUM_WORDS));
    assign o_rk   = r_rk;

endmodule

[hw/rtl/mlaes_round_cell.sv]
// One AES round cell of the cell row; passes the block through beyond the last round.
`timescale 1ns / 1ps
module mlaes_round_cell
    import mlaes_pkg::*;
#(
    parameter int ROUND = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_adv,
    input  t_tag         i_tag,
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    input  logic [3:0]   i_nr,
    output t_tag         o_tag,
    output logic [127:0] o_state
);

    t_tag         r_tag;
    logic [127:0] r_state;
    logic [127:0] n_state;

    always_comb begin
        if (4'(ROUND) <= i_nr) begin
            n_state = aes_round(i_state, 4'(ROUND) == i_nr) ^ i_key;
        end else begin
            n_state = i_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_adv) begin
            r_tag.valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tag.lane <= i_tag.lane;
            r_tag.last <= i_tag.last;
            r_state    <= n_state;
        end
    end

    assign o_tag   = r_tag;
    assign o_state = r_state;

endmodule

[hw/rtl/multi_lane_aes_cbc_encrypt.sv]
// Top level of the multi-lane AES-CBC encryptor: chain store, key schedule, round cell row.
//
//  channel  dir  handshake          payload
//  i_in     in   valid/ready        mode, lane, data_high, data_low, last_block
//  o_out    out  valid/ready        out_lane, cipher_high, cipher_low, out_last
//  i_cfg    in   i_cfg_we           i_cfg_idx, i_cfg_data (key words 0..3, key length)
//
// One request per cycle while the row advances, the key schedule is done and the lane
// is free; an encrypt block passes the front register with the chain read, 14 round
// cells and the output register, whatever the key length. A lane with an encrypt in
// flight takes no new request until its ciphertext is written back, so one lane never
// has two blocks in the row. After reset and every key write the key schedule runs
// with requests held off until done. A stalled result freezes the whole cell row.
`timescale 1ns / 1ps
module multi_lane_aes_cbc_encrypt
    import mlaes_pkg::*;
#(
    parameter int LANES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlaes_req_if.sink   i_in,
    mlaes_res_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    // Key registers and schedule.
    logic [63:0] r_key [4];
    logic [1:0]  r_key_len;
    logic        key_start;
    logic        key_done;
    t_word       rk [NUM_WORDS];
    logic [3:0]  nr;

    // Chain store and lane tracking.
    logic [127:0] r_chain [LANES];
    logic [127:0] r_rd;
    logic [LANES-1:0] r_busy;

    // Front stage holding the accepted block while its chain value is read.
    t_tag         r_s0_tag;
    logic [127:0] r_s0_data;

    // Cell row.
    t_tag         tag   [NUM_CELLS+1];
    logic [127:0] state [NUM_CELLS+1];

    // Output register.
    logic         r_ov;
    logic [5:0]   r_olane;
    logic [127:0] r_ocipher;
    logic         r_olast;

    logic          adv;
    logic          in_ok;
    logic          in_acc;
    logic          wb;
    logic [LW-1:0] in_idx;
    logic [LW-1:0] wb_idx;

    assign key_start = i_cfg_we && (i_cfg_idx <= CFG_KEYLEN);
    assign nr        = key_words(r_key_len) + 4'd6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
            r_key_len <= KL_AES128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY0:   r_key[0]  <= i_cfg_data;
                CFG_KEY1:   r_key[1]  <= i_cfg_data;
                CFG_KEY2:   r_key[2]  <= i_cfg_data;
                CFG_KEY3:   r_key[3]  <= i_cfg_data;
                CFG_KEYLEN: r_key_len <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    mlaes_key_expand u_key (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (key_start),
        .i_key     (r_key),
        .i_key_len (r_key_len),
        .o_rk      (rk),
        .o_done    (key_done)
    );

    // Advance the row whenever the output register is free or being drained.
    assign adv    = !r_ov || o_out.ready;
    assign in_ok  = 32'(i_in.lane) < LANES;
    assign in_idx = i_in.lane[LW-1:0];
    assign wb     = tag[NUM_CELLS].valid && adv;
    assign wb_idx = tag[NUM_CELLS].lane[LW-1:0];

    // Hold off during a stall or key expansion, a busy lane, and a load that would collide with a write-back.
    assign i_in.ready = adv && key_done && !(in_ok && r_busy[in_idx])
                        && !(i_in.mode == MODE_LOAD && wb);
    assign in_acc = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (wb) begin
            r_chain[wb_idx] <= state[NUM_CELLS];
        end else if (in_acc && in_ok && i_in.mode == MODE_LOAD) begin
            r_chain[in_idx] <= {i_in.data_high, i_in.data_low};
        end
        if (in_acc && in_ok && i_in.mode == MODE_ENCRYPT) begin
            r_rd <= r_chain[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            if (wb) begin
                r_busy[wb_idx] <= 1'b0;
            end
            if (in_acc && in_ok && i_in.mode == MODE_ENCRYPT) begin
                r_busy[in_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_tag.valid <= 1'b0;
        end else if (adv) begin
            r_s0_tag.valid <= in_acc && in_ok && i_in.mode == MODE_ENCRYPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_tag.lane <= i_in.lane;
            r_s0_tag.last <= i_in.last_block;
            r_s0_data     <= {i_in.data_high, i_in.data_low};
        end
    end

    // CBC xor and initial round key feed the first cell.
    assign tag[0]   = r_s0_tag;
    assign state[0] = r_s0_data ^ r_rd ^ {rk[0], rk[1], rk[2], rk[3]};

    for (genvar g = 1; g <= NUM_CELLS; g++) begin : g_cell
        mlaes_round_cell #(.ROUND(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tag   (tag[g-1]),
            .i_state (state[g-1]),
            .i_key   ({rk[4*g], rk[4*g+1], rk[4*g+2], rk[4*g+3]}),
            .i_nr    (nr),
            .o_tag   (tag[g]),
            .o_state (state[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= tag[NUM_CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_olane   <= tag[NUM_CELLS].lane;
            r_olast   <= tag[NUM_CELLS].last;
            r_ocipher <= state[NUM_CELLS];
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_lane    = r_olane;
    assign o_out.cipher_high = r_ocipher[127:64];
    assign o_out.cipher_low  = r_ocipher[63:0];
    assign o_out.out_last    = r_olast;

`ifndef SYNTHESIS
    a_wb_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wb |-> r_busy[wb_idx])
        else $error("write-back on a lane not marked busy");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.mode == MODE_LOAD) |-> !wb)
        else $error("load and write-back share the chain port");

    a_key_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_start |=> !key_done)
        else $error("key write did not restart the schedule");

    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_tag.valid |-> r_busy[r_s0_tag.lane[LW-1:0]])
        else $error("block in flight on an idle lane");
`endif

endmodule

[dv/tb_multi_lane_aes_cbc_encrypt.sv]
// Self-checking testbench of the multi-lane AES-CBC encryptor.
`timescale 1ns / 1ps
module tb_multi_lane_aes_cbc_encrypt;
    import mlaes_pkg::*;

    // One request as the driver offers it.
    typedef struct {
        t_mode       mode;
        logic [5:0]  lane;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic        last_block;
    } t_blk_req;

    // One ciphertext block as the monitor expects it.
    typedef struct {
        logic [5:0]  lane;
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
        logic        last;
    } t_cipher_blk;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [63:0] cfg_data;

    mlaes_req_if req_ch ();
    mlaes_res_if res_ch ();

    multi_lane_aes_cbc_encrypt #(.LANES(64)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Shadow copy of the key registers, the expanded schedule and the lane chains.
    logic [63:0]  key_reg [4];
    logic [1:0]   key_len_reg;
    logic [31:0]  sched_words [60];
    logic [127:0] lane_chain [64];
    bit           lane_primed [64];

    t_blk_req    pending_reqs [$];
    t_cipher_blk cipher_fifo  [$];

    int  errors;
    int  n_loads;
    int  n_encrypts;
    int  n_blocks_checked;
    int  n_phases;
    bit  req_taken;
    int  req_gap;
    int  rsp_gap;
    int  hold_left;
    bit  long_hold_req;
    bit  gapless;

    // Clock: 20 ns period.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // GF(2^8) multiply by two.
    function automatic logic [7:0] gf_mul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic int nk_of(input logic [1:0] kl);
        return (kl == KL_AES128) ? 4 : (kl == KL_AES192) ? 6 : 8;
    endfunction

    // Rebuild the round key schedule from the shadow key registers.
    function automatic void expand_schedule();
        int          nk;
        int          total;
        logic [31:0] t;
        logic [7:0]  rcon;
        nk    = nk_of(key_len_reg);
        total = 4 * (nk + 7);
        rcon  = 8'h01;
        for (int i = 0; i < 60; i++) begin
            sched_words[i] = 32'h0;
        end
        for (int i = 0; i < nk; i++) begin
            sched_words[i] = (i % 2) ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
        end
        for (int i = nk; i < total; i++) begin
            t = sched_words[i-1];
            if (i % nk == 0) begin
                t    = subst_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_mul2(rcon);
            end else if (nk > 6 && i % nk == 4) begin
                t = subst_word(t);
            end
            sched_words[i] = sched_words[i-nk] ^ t;
        end
    endfunction

    // Encrypt one 128-bit block under the current schedule; byte 0 is bits 127..120.
    function automatic logic [127:0] cipher_block(input logic [127:0] blk);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, x;
        logic [31:0]  w;
        logic [127:0] r;
        int           nr;
        nr = nk_of(key_len_reg) + 6;
        for (int i = 0; i < 16; i++) begin
            s[i] = blk[127-8*i -: 8];
        end
        for (int rnd = 0; rnd <= nr; rnd++) begin
            if (rnd > 0) begin
                for (int i = 0; i < 16; i++) begin
                    s[i] = SBOX[s[i]];
                end
                for (int c = 0; c < 4; c++) begin
                    for (int k = 0; k < 4; k++) begin
                        t[4*c+k] = s[4*((c+k)%4)+k];
                    end
                end
                s = t;
                if (rnd != nr) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        x  = a0 ^ a1 ^ a2 ^ a3;
                        s[4*c]   = a0 ^ x ^ gf_mul2(a0 ^ a1);
                        s[4*c+1] = a1 ^ x ^ gf_mul2(a1 ^ a2);
                        s[4*c+2] = a2 ^ x ^ gf_mul2(a2 ^ a3);
                        s[4*c+3] = a3 ^ x ^ gf_mul2(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++) begin
                w = sched_words[rnd*4+c];
                for (int k = 0; k < 4; k++) begin
                    s[4*c+k] ^= w[31-8*k -: 8];
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = s[i];
        end
        return r;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (gapless) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Predict on every accepted request: loads set the chain, encrypts make a block.
    always @(posedge i_clk) begin
        t_cipher_blk  e;
        logic [127:0] c;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            if (req_ch.mode == MODE_LOAD) begin
                lane_chain[req_ch.lane] = {req_ch.data_high, req_ch.data_low};
            end else begin
                c = cipher_block({req_ch.data_high, req_ch.data_low} ^
                                 lane_chain[req_ch.lane]);
                lane_chain[req_ch.lane] = c;
                e.lane        = req_ch.lane;
                e.cipher_high = c[127:64];
                e.cipher_low  = c[63:0];
                e.last        = req_ch.last_block;
                cipher_fifo.push_back(e);
            end
        end
    end

    // Driver: advance to the next request after acceptance, with random gaps.
    always @(negedge i_clk) begin
        t_blk_req r;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_taken) begin
            // hold the request until it is taken
        end else if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            r = pending_reqs.pop_front();
            req_ch.mode       <= r.mode;
            req_ch.lane       <= r.lane;
            req_ch.data_high  <= r.data_high;
            req_ch.data_low   <= r.data_low;
            req_ch.last_block <= r.last_block;
            req_ch.valid      <= 1'b1;
            req_gap = pick_gap();
        end else begin
            req_ch.valid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = 400;
            res_ch.ready <= 1'b0;
        end else if (rsp_gap > 0) begin
            rsp_gap--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
            rsp_gap = pick_gap();
        end
    end

    // Monitor: compare each ciphertext block with the oldest prediction.
    always @(posedge i_clk) begin
        t_cipher_blk e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (cipher_fifo.size() == 0) begin
                errors++;
                $display("%0t: unexpected block: expected none, actual lane %0d %h%h",
                         $time, res_ch.out_lane, res_ch.cipher_high, res_ch.cipher_low);
            end else begin
                e = cipher_fifo.pop_front();
                n_blocks_checked++;
                if (res_ch.out_lane !== e.lane) begin
                    errors++;
                    $display("%0t: out_lane mismatch: expected %0d, actual %0d",
                             $time, e.lane, res_ch.out_lane);
                end
                if (res_ch.cipher_high !== e.cipher_high) begin
                    errors++;
                    $display("%0t: cipher_high mismatch: expected %h, actual %h",
                             $time, e.cipher_high, res_ch.cipher_high);
                end
                if (res_ch.cipher_low !== e.cipher_low) begin
                    errors++;
                    $display("%0t: cipher_low mismatch: expected %h, actual %h",
                             $time, e.cipher_low, res_ch.cipher_low);
                end
                if (res_ch.out_last !== e.last) begin
                    errors++;
                    $display("%0t: out_last mismatch: expected %b, actual %b",
                             $time, e.last, res_ch.out_last);
                end
            end
        end
    end

    // Write one key register at a falling edge and mirror it in the shadow copy.
    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        if (idx == CFG_KEYLEN) key_len_reg = val[1:0];
        else                   key_reg[idx[1:0]] = val;
        expand_schedule();
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_key(input logic [63:0] k0, k1, k2, k3, input logic [1:0] kl);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_KEYLEN, {62'h0, kl});
    endtask

    task automatic queue_req(input t_mode m, input logic [5:0] ln,
                             input logic [63:0] hi, lo, input logic lst);
        t_blk_req r;
        r.mode = m; r.lane = ln; r.data_high = hi; r.data_low = lo; r.last_block = lst;
        if (m == MODE_LOAD) begin
            lane_primed[ln] = 1'b1;
            n_loads++;
        end else begin
            n_encrypts++;
        end
        pending_reqs.push_back(r);
    endtask

    // Drain everything, then let the pipeline settle before touching the keys.
    task automatic drain();
        wait (pending_reqs.size() == 0 && !req_ch.valid && cipher_fifo.size() == 0);
        repeat (25) @(posedge i_clk);
    endtask

    // Mostly well-formed messages: load a lane IV, then blocks with random content.
    task automatic random_phase(input int n);
        logic [5:0] ln;
        n_phases++;
        for (int k = 0; k < n; k++) begin
            ln = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, 63));
            if (!lane_primed[ln] || $urandom_range(0, 7) == 0) begin
                queue_req(MODE_LOAD, ln, pick_word(), pick_word(), 1'($urandom_range(0, 1)));
            end else begin
                queue_req(MODE_ENCRYPT, ln, pick_word(), pick_word(),
                          $urandom_range(0, 7) == 0);
            end
        end
        drain();
    endtask

    initial begin
        errors = 0; n_loads = 0; n_encrypts = 0; n_blocks_checked = 0; n_phases = 0;
        req_taken = 0; req_gap = 0; rsp_gap = 0; hold_left = 0;
        long_hold_req = 0; gapless = 0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0; cfg_idx = CFG_KEY0; cfg_data = 64'h0;
        req_ch.valid = 1'b0; req_ch.mode = MODE_LOAD; req_ch.lane = '0;
        req_ch.data_high = '0; req_ch.data_low = '0; req_ch.last_block = 1'b0;
        res_ch.ready = 1'b0;
        for (int i = 0; i < 4; i++) key_reg[i] = 64'h0;
        key_len_reg = KL_AES128;
        for (int i = 0; i < 64; i++) begin
            lane_chain[i]  = '0;
            lane_primed[i] = 1'b0;
        end
        expand_schedule();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset key, field extremes, reload and back-to-back blocks.
        n_phases++;
        queue_req(MODE_LOAD,    6'd0,  64'h0, 64'h0, 1'b0);
        queue_req(MODE_ENCRYPT, 6'd0,  64'h0, 64'h0, 1'b0);
        queue_req(MODE_LOAD,    6'd63, '1, '1, 1'b1);
        queue_req(MODE_ENCRYPT, 6'd63, '1, '1, 1'b1);
        queue_req(MODE_ENCRYPT, 6'd63, 64'h0, '1, 1'b0);
        queue_req(MODE_ENCRYPT, 6'd0,  '1, 64'h0, 1'b1);
        queue_req(MODE_LOAD,    6'd0,  64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        queue_req(MODE_ENCRYPT, 6'd0,  64'h0, 64'h0, 1'b0);
        for (int i = 1; i < 6; i++) begin
            queue_req(MODE_LOAD, i[5:0], pick_word(), pick_word(), 1'b0);
        end
        for (int i = 1; i < 6; i++) begin
            queue_req(MODE_ENCRYPT, i[5:0], pick_word(), pick_word(), i[0]);
        end
        drain();

        // Standard test key in each length; chains carry over across the key change.
        set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, 64'h18191a1b1c1d1e1f, KL_AES128);
        queue_req(MODE_LOAD,    6'd7, 64'h0, 64'h0, 1'b0);
        queue_req(MODE_ENCRYPT, 6'd7, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        queue_req(MODE_ENCRYPT, 6'd0, pick_word(), pick_word(), 1'b0);
        drain();
        random_phase(200);

        write_reg(CFG_KEYLEN, {62'h0, KL_AES192});
        random_phase(200);

        // Receiver holds off long while requests keep coming, no source gaps.
        write_reg(CFG_KEYLEN, {62'h0, KL_AES256});
        gapless       = 1'b1;
        long_hold_req = 1'b1;
        random_phase(250);
        gapless = 1'b0;

        // Key length three behaves as the 256-bit key.
        set_key('1, '1, '1, '1, KL_ALIAS);
        random_phase(200);

        set_key(64'h0, 64'h0, 64'h0, 64'h0, KL_AES256);
        random_phase(150);

        for (int p = 0; p < 3; p++) begin
            set_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, 2'($urandom_range(0, 3)));
            random_phase(170);
        end

        $display("Covered %0d phases, %0d IV loads, %0d encrypts, %0d blocks checked.",
                 n_phases, n_loads, n_encrypts, n_blocks_checked);
        $display("Key lengths 128/192/256 and alias, long result hold-off, %0d errors.",
                 errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
